// ----- hdl/mbad_pkg.sv -----
// Shared constants and types for the masked block average downsampler.
`default_nettype none

package mbad_pkg;

    localparam int COORD_W    = 32;
    localparam int NLANE      = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RATIO  = 8;
    localparam int ROW_LIMIT  = 1024;
    localparam int RATIO_W    = 4;
    localparam int DIM_W      = 11;
    localparam int EXT_W      = DIM_W + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(ROW_LIMIT);
    localparam int SUB_W      = $clog2(MAX_RATIO);
    localparam int CNT_W      = $clog2(MAX_RATIO * MAX_RATIO) + 1;
    localparam int SUM_W      = COORD_W + CNT_W - 1;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int IN_DATA_W  = NLANE * COORD_W;
    localparam int OUT_BITS   = NLANE * COORD_W + COL_W + ROW_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [NLANE-1:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]            cnt;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic acc_wr;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_block;
        logic item_end;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/mbad_ctrl.sv -----
// Sequencer for the masked block average downsampler.
`default_nettype none

module mbad_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  mbad_pkg::t_stat i_stat,
    output mbad_pkg::t_cmd  o_cmd
);
    import mbad_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_block) n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc_wr = 1'b1;
                if (i_stat.item_end) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

// ----- hdl/mbad_dp.sv -----
// Datapath: position counters, block line buffer, serial dividers, output register.
`default_nettype none

module mbad_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mbad_pkg::t_cmd                     i_cmd,
    output mbad_pkg::t_stat                    o_stat,
    input  logic [mbad_pkg::RATIO_W-1:0]       i_ratio,
    input  logic [mbad_pkg::DIM_W-1:0]         i_width,
    input  logic [mbad_pkg::DIM_W-1:0]         i_height,
    input  logic                               i_restart,
    input  logic [mbad_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mbad_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);
    import mbad_pkg::*;

    // frame position
    logic [COL_W-1:0] r_pix_col, r_blk_col, r_bst_col;
    logic [SUB_W-1:0] r_sub_col;
    logic [ROW_W-1:0] r_pix_row, r_blk_row, r_bst_row;
    logic [SUB_W-1:0] r_sub_row;

    logic col_wrap, row_wrap, sub_col_wrap, sub_row_wrap;
    logic in_col, in_row, last_col, last_row, first_px, end_px;

    // latched word
    logic                         r_first, r_end, r_flast, r_finite;
    logic [COL_W-1:0]             r_addr;
    logic [ROW_W-1:0]             r_brow;
    logic [NLANE-1:0][COORD_W-1:0] r_crd;

    // line buffer
    t_entry r_mem [MAX_WIDTH];
    t_entry r_rd;
    t_entry base;
    t_entry n_entry;

    // dividers
    logic [NLANE-1:0][SUM_W-1:0] r_quo, n_quo;
    logic [NLANE-1:0][CNT_W-1:0] r_rem, n_rem;
    logic [NLANE-1:0]            r_neg;
    logic [CNT_W-1:0]            r_den;
    logic [DIV_CNT_W-1:0]        r_div_cnt;
    logic [NLANE-1:0][CNT_W:0]   trial;
    logic [NLANE-1:0][SUM_W-1:0] mag;

    // output
    logic                  r_out_valid, r_out_user, r_out_last;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [SUM_W-1:0]      quot;

    assign sub_col_wrap = (RATIO_W'(r_sub_col) + RATIO_W'(1)) >= i_ratio;
    assign sub_row_wrap = (RATIO_W'(r_sub_row) + RATIO_W'(1)) >= i_ratio;
    assign col_wrap     = (DIM_W'(r_pix_col) + DIM_W'(1)) >= i_width;
    assign row_wrap     = (DIM_W'(r_pix_row) + DIM_W'(1)) >= i_height;
    assign in_col   = (EXT_W'(r_bst_col) + EXT_W'(i_ratio)) <= EXT_W'(i_width);
    assign in_row   = (EXT_W'(r_bst_row) + EXT_W'(i_ratio)) <= EXT_W'(i_height);
    assign last_col = (EXT_W'(r_bst_col) + EXT_W'({i_ratio, 1'b0})) > EXT_W'(i_width);
    assign last_row = (EXT_W'(r_bst_row) + EXT_W'({i_ratio, 1'b0})) > EXT_W'(i_height);
    assign first_px = (r_sub_col == '0) && (r_sub_row == '0);
    assign end_px   = (RATIO_W'(r_sub_col) == i_ratio - RATIO_W'(1))
                   && (RATIO_W'(r_sub_row) == i_ratio - RATIO_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pix_col <= '0;
            r_blk_col <= '0;
            r_bst_col <= '0;
            r_sub_col <= '0;
            r_pix_row <= '0;
            r_blk_row <= '0;
            r_bst_row <= '0;
            r_sub_row <= '0;
        end else if (i_cmd.accept) begin
            if (col_wrap) begin
                r_pix_col <= '0;
                r_blk_col <= '0;
                r_bst_col <= '0;
                r_sub_col <= '0;
                if (row_wrap) begin
                    r_pix_row <= '0;
                    r_blk_row <= '0;
                    r_bst_row <= '0;
                    r_sub_row <= '0;
                end else begin
                    r_pix_row <= r_pix_row + ROW_W'(1);
                    if (sub_row_wrap) begin
                        r_sub_row <= '0;
                        r_blk_row <= r_blk_row + ROW_W'(1);
                        r_bst_row <= r_bst_row + ROW_W'(i_ratio);
                    end else begin
                        r_sub_row <= r_sub_row + SUB_W'(1);
                    end
                end
            end else begin
                r_pix_col <= r_pix_col + COL_W'(1);
                if (sub_col_wrap) begin
                    r_sub_col <= '0;
                    r_blk_col <= r_blk_col + COL_W'(1);
                    r_bst_col <= r_bst_col + COL_W'(i_ratio);
                end else begin
                    r_sub_col <= r_sub_col + SUB_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_first  <= first_px;
            r_end    <= end_px;
            r_flast  <= last_col && last_row;
            r_addr   <= r_blk_col;
            r_brow   <= r_blk_row;
            r_finite <= i_s_tuser;
            r_crd    <= i_s_tdata;
        end
    end

    always_comb begin
        base    = r_first ? '0 : r_rd;
        n_entry = base;
        for (int l = 0; l < NLANE; l++) begin
            if (r_finite) begin
                n_entry.sum[l] = base.sum[l]
                    + {{(SUM_W-COORD_W){r_crd[l][COORD_W-1]}}, r_crd[l]};
            end
        end
        n_entry.cnt = base.cnt + CNT_W'(r_finite);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_wr) r_mem[r_addr] <= n_entry;
        if (i_cmd.accept) r_rd <= r_mem[r_blk_col];
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            mag[l]   = n_entry.sum[l][SUM_W-1] ? -n_entry.sum[l] : n_entry.sum[l];
            trial[l] = {r_rem[l], r_quo[l][SUM_W-1]};
            if (trial[l] >= {1'b0, r_den}) begin
                n_rem[l] = CNT_W'(trial[l] - {1'b0, r_den});
                n_quo[l] = {r_quo[l][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[l] = trial[l][CNT_W-1:0];
                n_quo[l] = {r_quo[l][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            for (int l = 0; l < NLANE; l++) begin
                r_neg[l] <= n_entry.sum[l][SUM_W-1];
            end
            r_quo     <= mag;
            r_rem     <= '0;
            r_den     <= n_entry.cnt;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= n_quo;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    always_comb begin
        n_out_data = '0;
        quot       = '0;
        for (int l = 0; l < NLANE; l++) begin
            quot = r_neg[l] ? -r_quo[l] : r_quo[l];
            if (r_den != '0) begin
                n_out_data[l*COORD_W +: COORD_W] = quot[COORD_W-1:0];
            end
        end
        n_out_data[NLANE*COORD_W +: COL_W]         = r_addr;
        n_out_data[NLANE*COORD_W + COL_W +: ROW_W] = r_brow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= n_out_data;
            r_out_user <= (r_den != '0);
            r_out_last <= r_flast;
        end
    end

    assign o_stat.in_block = in_col && in_row;
    assign o_stat.item_end = r_end;
    assign o_stat.div_last = (r_div_cnt == DIV_CNT_W'(SUM_W - 1));
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/masked_block_average_downsampler.sv -----
// Top level: register port, sequencer and datapath of the block average downsampler.
// Flow: a word outside every block is only counted; a word inside a block is summed
// into the line buffer; a word that closes a block runs the 38-step divider per
// coordinate, waits for a free output register, and only then takes the next word.
// Reset: synchronous, active low; clears control, position and config to defaults.
// The line buffer is not cleared; every block writes its entry on its first pixel.
`default_nettype none

module masked_block_average_downsampler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mbad_pkg::IN_DATA_W-1:0]     i_s_tdata,  // coord_x, coord_y, coord_z
    input  logic                               i_s_tuser,  // is_finite
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mbad_pkg::OUT_DATA_W-1:0]    o_m_tdata,  // avg_x, avg_y, avg_z,
                                                           // out_column, out_row_index
    output logic                               o_m_tuser,  // point_valid
    output logic                               o_m_tlast,  // frame_last
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import mbad_pkg::*;

    localparam logic [1:0] REG_RATIO  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    logic [RATIO_W-1:0] r_ratio, ratio_c;
    logic [DIM_W-1:0]   r_width, r_height, width_c, height_c;
    logic               cfg_wr, restart;
    logic [1:0]         reg_idx;
    t_cmd               cmd;
    t_stat              stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign restart = cfg_wr && (reg_idx == REG_RATIO || reg_idx == REG_WIDTH
                                || reg_idx == REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio  <= RATIO_W'(1);
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(480);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RATIO:  r_ratio  <= pwdata[RATIO_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RATIO:  prdata = 32'(r_ratio);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_ratio == '0)                         ratio_c = RATIO_W'(1);
        else if (r_ratio > RATIO_W'(MAX_RATIO))    ratio_c = RATIO_W'(MAX_RATIO);
        else                                       ratio_c = r_ratio;
        if (r_width == '0)                         width_c = DIM_W'(1);
        else if (r_width > DIM_W'(MAX_WIDTH))      width_c = DIM_W'(MAX_WIDTH);
        else                                       width_c = r_width;
        if (r_height == '0)                        height_c = DIM_W'(1);
        else if (r_height > DIM_W'(ROW_LIMIT))     height_c = DIM_W'(ROW_LIMIT);
        else                                       height_c = r_height;
    end

    mbad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mbad_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_ratio    (ratio_c),
        .i_width    (width_c),
        .i_height   (height_c),
        .i_restart  (restart),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- hdl/mbad_checker.sv -----
// Port-level checks for the block average downsampler, bound to the top level.
`default_nettype none

module mbad_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [mbad_pkg::OUT_DATA_W-1:0] i_out_data,
    input logic                            i_out_user
);
    import mbad_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output word dropped or changed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_user |-> i_out_data[NLANE*COORD_W-1:0] == '0)
        else $error("invalid block carries nonzero coordinates");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data[OUT_DATA_W-1:OUT_BITS] == '0)
        else $error("pad bits of output word not zero");

endmodule

bind masked_block_average_downsampler mbad_checker u_mbad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_tvalid),
    .i_out_ready (i_m_tready),
    .i_out_data  (o_m_tdata),
    .i_out_user  (o_m_tuser)
);

`default_nettype wire
